>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of the MurmurHash2 stream core.
// Depends on nothing; each macro takes a label, a clock, an active-low reset and two expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle assertion failed");

// The consequent must hold starting in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`endif

>>> rtl/mh2_pkg.sv
// Package for the MurmurHash2 stream core: constants, sequencer states, multiplier request type.
// Depends on nothing; imported by the core, the multiplier and the testbench.
package mh2_pkg;

    localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
    localparam int unsigned MIX_SHIFT   = 24;
    localparam int unsigned FIN_SHIFT_A = 13;
    localparam int unsigned FIN_SHIFT_B = 15;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_K1   = 6'b000010,
        ST_K2   = 6'b000100,
        ST_K3   = 6'b001000,
        ST_TAIL = 6'b010000,
        ST_AVAL = 6'b100000
    } state_t;

    typedef struct packed {
        logic        en;
        logic [31:0] operand;
    } mul_req_t;

    function automatic logic [31:0] xor_shift(input logic [31:0] v, input int unsigned sh);
        xor_shift = v ^ (v >> sh);
    endfunction

    function automatic logic [31:0] tail_mask(input logic [2:0] count);
        case (count)
            3'd1:    tail_mask = 32'h0000_00ff;
            3'd2:    tail_mask = 32'h0000_ffff;
            default: tail_mask = 32'h00ff_ffff;
        endcase
    endfunction

endpackage

>>> rtl/mh2_mul.sv
// Shared multiplier: registers, when the request is enabled, the low 32 bits of the operand times the mixing constant.
// Depends on mh2_pkg for the constant and the request type.
module mh2_mul
    import mh2_pkg::*;
(
    input  logic        clk,
    input  mul_req_t    req,
    output logic [31:0] product
);

    logic [31:0] product_reg;
    logic [31:0] product_next;

    assign product_next = req.operand * MIX_MUL;

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            product_reg <= product_next;
        end
    end

    assign product = product_reg;

endmodule

>>> rtl/murmur2_hash32_stream_core.sv
// Top level of the streaming 32-bit MurmurHash2 core: sequencer, hash state and output register.
// Depends on mh2_pkg and on the shared multiplier mh2_mul.
//
// Each input transaction carries one little-endian message word; the core is not ready while it
// works on a word. All multiplications go through one shared multiplier whose product is
// registered: a full word passes ST_K1, ST_K2 and ST_K3, a partial word ST_TAIL, an empty word
// none, and a last word adds ST_AVAL for the final avalanche multiply. The finished hash sits in
// an output register, so the next word is taken while a hash still waits; the core stalls
// only if a second hash is ready before the first is taken. The seed register is written with
// seed_we and seed_wdata; the user must do so only while the core idles, which is not enforced.
module murmur2_hash32_stream_core
    import mh2_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        seed_we,
    input  logic [31:0] seed_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] data_word,
    input  logic [2:0]  byte_count,
    input  logic        is_first,
    input  logic        is_last,
    input  logic [30:0] message_length,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] hash_value
);

    state_t      state_reg, state_next;
    logic [31:0] seed_reg;
    logic [31:0] running_hash_reg, running_hash_next;
    logic [31:0] k_reg, k_next;
    logic        last_reg, last_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] hash_reg, hash_next;
    logic [31:0] h_start;
    logic [31:0] product;
    logic [31:0] mixed;
    mul_req_t    mul_req;

    mh2_mul u_mul (
        .clk     (clk),
        .req     (mul_req),
        .product (product)
    );

    assign h_start = is_first ? ({1'b0, message_length} ^ seed_reg) : running_hash_reg;
    assign mixed   = product ^ k_reg;

    always_comb
    begin
        state_next        = state_reg;
        running_hash_next = running_hash_reg;
        k_next            = k_reg;
        last_next         = last_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        hash_next         = hash_reg;
        mul_req.en        = 1'b0;
        mul_req.operand   = 32'h0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    running_hash_next = h_start;
                    last_next         = is_last;
                    if (byte_count[2])
                    begin
                        mul_req.en      = 1'b1;
                        mul_req.operand = data_word;
                        state_next      = ST_K1;
                    end
                    else if (byte_count[1:0] != 2'b00)
                    begin
                        mul_req.en      = 1'b1;
                        mul_req.operand = h_start ^ (data_word & tail_mask(byte_count));
                        state_next      = ST_TAIL;
                    end
                    else if (is_last)
                    begin
                        mul_req.en      = 1'b1;
                        mul_req.operand = xor_shift(h_start, FIN_SHIFT_A);
                        state_next      = ST_AVAL;
                    end
                end
            end
            ST_K1:
            begin
                mul_req.en      = 1'b1;
                mul_req.operand = xor_shift(product, MIX_SHIFT);
                state_next      = ST_K2;
            end
            ST_K2:
            begin
                k_next          = product;
                mul_req.en      = 1'b1;
                mul_req.operand = running_hash_reg;
                state_next      = ST_K3;
            end
            ST_K3:
            begin
                running_hash_next = mixed;
                if (last_reg)
                begin
                    mul_req.en      = 1'b1;
                    mul_req.operand = xor_shift(mixed, FIN_SHIFT_A);
                    state_next      = ST_AVAL;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_TAIL:
            begin
                running_hash_next = product;
                if (last_reg)
                begin
                    mul_req.en      = 1'b1;
                    mul_req.operand = xor_shift(product, FIN_SHIFT_A);
                    state_next      = ST_AVAL;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_AVAL:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    hash_next      = xor_shift(product, FIN_SHIFT_B);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            seed_reg         <= 32'h0;
            running_hash_reg <= 32'h0;
            last_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            running_hash_reg <= running_hash_next;
            last_reg         <= last_next;
            out_valid_reg    <= out_valid_next;
            if (seed_we)
            begin
                seed_reg <= seed_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        hash_reg <= hash_next;
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign hash_value = hash_reg;

endmodule

>>> rtl/mh2_checker.sv
// Port-level checker for the MurmurHash2 stream core, bound to the top level.
// Depends on assert_macros.svh and on the ports of murmur2_hash32_stream_core.
`include "assert_macros.svh"

module mh2_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [2:0]  byte_count,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] hash_value
);

    // A stalled result transaction keeps its hash.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(hash_value))

    // A full word keeps the core busy for its multiplier passes.
    `ASSERT_NEXT(a_full_busy, clk, rst_n, in_valid && in_ready && byte_count[2], !in_ready ##1 !in_ready)

    // A word with bytes is never finished in the cycle it is accepted.
    `ASSERT_NEXT(a_word_busy, clk, rst_n, in_valid && in_ready && (byte_count != 3'd0), !in_ready)

    // A new hash appears only out of the busy avalanche step.
    `ASSERT_SAME(a_rise_busy, clk, rst_n, $rose(out_valid), $past(!in_ready))

endmodule

bind murmur2_hash32_stream_core mh2_checker u_mh2_checker (.*);

>>> test/tb_murmur2_hash32_stream_core.sv
// Testbench for murmur2_hash32_stream_core: streams messages through the core and checks each hash.
// Depends on mh2_pkg and the core RTL; the expected hashes come from a predictor in this file.
`timescale 1ns / 1ps

module tb_murmur2_hash32_stream_core;
    import mh2_pkg::*;

    typedef struct {
        bit [31:0] word;
        bit [2:0]  nbytes;
        bit        first;
        bit        last;
        bit [30:0] len;
    } msg_word_t;

    localparam int unsigned IDLE_PCT     = 33;
    localparam int unsigned STALL_AT     = 300;
    localparam int unsigned STALL_CYCLES = 400;
    localparam int unsigned RANDOM_WORDS = 250;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        seed_we = 1'b0;
    logic [31:0] seed_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] data_word = '0;
    logic [2:0]  byte_count = '0;
    logic        is_first = 1'b0;
    logic        is_last = 1'b0;
    logic [30:0] message_length = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] hash_value;

    msg_word_t   pending_words[$];
    bit [31:0]   hash_expect_q[$];
    bit [31:0]   hash_state = '0;
    bit [31:0]   seed_reg = '0;
    bit          word_taken = 1'b0;
    bit          no_idle = 1'b0;
    bit          stall_used = 1'b0;
    int unsigned stall_left = 0;
    int unsigned words_in = 0;
    int unsigned mismatches = 0;

    murmur2_hash32_stream_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .seed_we        (seed_we),
        .seed_wdata     (seed_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_word      (data_word),
        .byte_count     (byte_count),
        .is_first       (is_first),
        .is_last        (is_last),
        .message_length (message_length),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .hash_value     (hash_value)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what, input bit [31:0] got,
                                   input bit [31:0] want);
        $display("ERROR %0t: %s: got %08h, expected %08h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic absorb_word(input msg_word_t w);
        bit [31:0] k;
        bit [31:0] mask;
        bit [31:0] h;
        if (w.first)
        begin
            hash_state = {1'b0, w.len} ^ seed_reg;
        end
        if (w.nbytes >= 3'd4)
        begin
            k = w.word * MIX_MUL;
            k = k ^ (k >> MIX_SHIFT);
            k = k * MIX_MUL;
            hash_state = (hash_state * MIX_MUL) ^ k;
        end
        else if (w.nbytes != 3'd0)
        begin
            mask = (w.nbytes == 3'd1) ? 32'h0000_00ff :
                   (w.nbytes == 3'd2) ? 32'h0000_ffff : 32'h00ff_ffff;
            hash_state = (hash_state ^ (w.word & mask)) * MIX_MUL;
        end
        if (w.last)
        begin
            h = hash_state ^ (hash_state >> FIN_SHIFT_A);
            h = h * MIX_MUL;
            h = h ^ (h >> FIN_SHIFT_B);
            hash_expect_q.push_back(h);
        end
    endtask

    task automatic push_word(input bit [31:0] word, input bit [2:0] nbytes, input bit first,
                             input bit last, input bit [30:0] len);
        msg_word_t w;
        w.word = word;
        w.nbytes = nbytes;
        w.first = first;
        w.last = last;
        w.len = len;
        pending_words.push_back(w);
    endtask

    task automatic push_message(input int unsigned nbytes, input bit [30:0] len,
                                output int unsigned nwords);
        int unsigned left;
        left = nbytes;
        nwords = 0;
        if (nbytes == 0)
        begin
            push_word($urandom(), 3'd0, 1'b1, 1'b1, len);
            nwords = 1;
        end
        while (left != 0)
        begin
            push_word($urandom(), (left >= 4) ? 3'd4 : left[2:0], nwords == 0, left <= 4, len);
            left = (left >= 4) ? left - 4 : 0;
            nwords++;
        end
    endtask

    task automatic queue_random_traffic(input int unsigned target);
        int unsigned added;
        int unsigned nwords;
        int unsigned nbytes;
        int unsigned pick;
        bit [30:0]   len;
        added = 0;
        while (added < target)
        begin
            pick = $urandom_range(99);
            if (pick < 85)
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                    nbytes = $urandom_range(24);
                else if (pick < 95)
                    nbytes = $urandom_range(200, 25);
                else
                    nbytes = $urandom_range(600, 201);
                len = ($urandom_range(99) < 90) ? nbytes[30:0] : 31'($urandom());
                push_message(nbytes, len, nwords);
                added += nwords;
            end
            else
            begin
                push_word($urandom(), 3'($urandom_range(7)), 1'($urandom_range(1)),
                          1'($urandom_range(1)), 31'($urandom()));
                added++;
            end
        end
    endtask

    task automatic drain_and_settle();
        while (pending_words.size() != 0 || in_valid || hash_expect_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_seed(input bit [31:0] value);
        @(negedge clk);
        seed_we <= 1'b1;
        seed_wdata <= value;
        @(negedge clk);
        seed_we <= 1'b0;
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin : watch_ports
        msg_word_t w;
        bit [31:0] want;
        word_taken = 1'b0;
        if (rst_n)
        begin
            if (seed_we)
                seed_reg = seed_wdata;
            if (in_valid && in_ready)
            begin
                w.word = data_word;
                w.nbytes = byte_count;
                w.first = is_first;
                w.last = is_last;
                w.len = message_length;
                absorb_word(w);
                word_taken = 1'b1;
                words_in++;
            end
            if (out_valid && out_ready)
            begin
                if (hash_expect_q.size() == 0)
                    report_mismatch("hash with no message outstanding", hash_value, '0);
                else
                begin
                    want = hash_expect_q.pop_front();
                    if (hash_value !== want)
                        report_mismatch("hash_value mismatch", hash_value, want);
                end
            end
        end
    end

    always @(negedge clk)
    begin : drive_words
        msg_word_t w;
        if (rst_n && (!in_valid || word_taken))
        begin
            if (pending_words.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT))
            begin
                w = pending_words.pop_front();
                in_valid <= 1'b1;
                data_word <= w.word;
                byte_count <= w.nbytes;
                is_first <= w.first;
                is_last <= w.last;
                message_length <= w.len;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin : drive_ready
        if (!stall_used && words_in >= STALL_AT)
        begin
            stall_used = 1'b1;
            stall_left = STALL_CYCLES;
        end
        if (stall_left != 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= rst_n && (no_idle || $urandom_range(99) >= IDLE_PCT);
        end
    end

    initial
    begin : run_phases
        bit [31:0] seeds[5];
        seeds[0] = 32'hffff_ffff;
        seeds[1] = 32'h0000_0000;
        seeds[2] = $urandom();
        seeds[3] = 32'h8000_0000;
        seeds[4] = $urandom();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Words before any first word continue from the cleared hash state.
        push_word(32'hffff_ffff, 3'd4, 1'b0, 1'b0, 31'h7fff_ffff);
        push_word(32'h0000_0000, 3'd0, 1'b0, 1'b1, 31'h0000_0000);
        push_word(32'h1234_5678, 3'd3, 1'b0, 1'b1, 31'h0000_0000);
        push_word(32'hdead_beef, 3'd0, 1'b1, 1'b1, 31'h0000_0000);
        push_word(32'h0000_0000, 3'd0, 1'b1, 1'b1, 31'h7fff_ffff);
        push_word(32'hffff_ffff, 3'd1, 1'b1, 1'b1, 31'd1);
        push_word(32'hffff_ffff, 3'd2, 1'b1, 1'b1, 31'd2);
        push_word(32'hffff_ffff, 3'd3, 1'b1, 1'b1, 31'd3);
        push_word(32'ha5a5_a5a5, 3'd5, 1'b1, 1'b1, 31'd4);
        push_word(32'h5a5a_5a5a, 3'd6, 1'b1, 1'b1, 31'd4);
        push_word(32'hffff_ffff, 3'd7, 1'b1, 1'b1, 31'd4);
        push_word(32'hcafe_0102, 3'd2, 1'b1, 1'b0, 31'd9);
        push_word(32'h0403_0201, 3'd4, 1'b0, 1'b0, 31'd9);
        push_word(32'h8877_6655, 3'd3, 1'b0, 1'b1, 31'd9);
        push_word(32'h0000_0000, 3'd4, 1'b1, 1'b0, 31'd8);
        push_word(32'hffff_ffff, 3'd4, 1'b0, 1'b1, 31'd8);
        push_word(32'h0bad_f00d, 3'd4, 1'b1, 1'b0, 31'd12);
        push_word(32'h1357_9bdf, 3'd4, 1'b1, 1'b1, 31'd4);
        push_word(32'h2468_ace0, 3'd4, 1'b0, 1'b1, 31'h5555_5555);
        queue_random_traffic(RANDOM_WORDS);
        drain_and_settle();

        for (int p = 0; p < 5; p++)
        begin
            write_seed(seeds[p]);
            no_idle = (p == 2);
            queue_random_traffic(RANDOM_WORDS);
            drain_and_settle();
        end

        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("murmur2_hash32_stream_core test passed");
        else
            $display("murmur2_hash32_stream_core test failed");
        $finish;
    end

    initial
    begin : watchdog
        #5000000;
        $display("murmur2_hash32_stream_core test failed");
        $finish;
    end

endmodule
